>>> hw/rtl/tlph_pkg.sv
package tlph_pkg;

    localparam int KEY_W      = 64;
    localparam int HASH_W     = 64;
    localparam int ROW_W      = 64;
    localparam int TAG_W      = 8;
    localparam int SLOT_W     = 10;
    localparam int CAP_LOG_W  = 4;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 80;

    localparam logic [CAP_LOG_W-1:0] CAP_LOG_RESET = 4'd10;

    localparam logic [TAG_W-1:0] TAG_EMPTY = 8'h80;
    localparam int TAG_LSB = 57;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;

    localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_CLEARED   = 3'd6;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
        logic [ROW_W-1:0] row;
    } slot_entry_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
        logic [HASH_W-1:0]   hash;
        logic [ROW_W-1:0]    row;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ROW_W-1:0]    row;
        logic [SLOT_W-1:0]   slot;
    } result_t;

endpackage

>>> hw/rtl/tagged_linear_probe_hash_index_top.sv
// Key-to-row index over an open-addressed table with linear probing.
// Requests arrive on the s_axis channel: tuser carries the action (clear,
// insert, lookup) and tdata carries the key, its precomputed hash and the row.
// Each request gives one result transfer on m_axis: tuser is the status and
// tdata carries the found row and the slot.
// For a lookup or insert, the controller goes from issue to probe, probing
// slots in turn, and then to done. The slot memory delivers one
// slot per cycle, and the single key and tag comparator examines it.
// A new request is accepted only once the previous result has gone to the output register.
// A clear sweeps all MAX_SLOTS slots, one per cycle, and then gives its result.
// After reset the same sweep runs with s_axis_tready low.
// The capacity register may be written at any time the block is idle; it does
// not empty the table, so a clear should follow a change.
// A finished result waits in an output register while m_axis_tready is low;
// the next request is accepted and probed meanwhile, and its result is held
// back until the output register is free.
module tagged_linear_probe_hash_index_top #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [tlph_pkg::CAP_LOG_W-1:0]      cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: key, key_hash, row_value.
    input  logic [tlph_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Fields from bit 0: action.
    input  logic [tlph_pkg::ACTION_W-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: found_row, slot_used, then zero padding.
    output logic [tlph_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Fields from bit 0: status.
    output logic [tlph_pkg::STATUS_W-1:0]       m_axis_tuser
);
    import tlph_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    logic [CAP_LOG_W-1:0] capacity_reg;
    logic                 out_valid_reg;
    result_t              out_reg;

    request_t    req;
    result_t     res;
    logic        res_valid;
    logic        res_ready;
    logic        mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [AW-1:0] mem_rd_addr;
    slot_entry_t mem_wr_data;
    slot_entry_t mem_rd_data;

    assign req.action = s_axis_tuser;
    assign req.key    = s_axis_tdata[KEY_W-1:0];
    assign req.hash   = s_axis_tdata[KEY_W+HASH_W-1:KEY_W];
    assign req.row    = s_axis_tdata[KEY_W+HASH_W+ROW_W-1:KEY_W+HASH_W];

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_LOG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    tlph_probe_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .capacity_log2 (capacity_reg),
        .req_valid     (s_axis_tvalid),
        .req_ready     (s_axis_tready),
        .req           (req),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rd_data   (mem_rd_data)
    );

    tlph_slot_mem #(
        .MAX_SLOTS (MAX_SLOTS),
        .AW        (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {{(OUT_DATA_W - ROW_W - SLOT_W){1'b0}}, out_reg.slot, out_reg.row};

endmodule

>>> hw/rtl/tlph_slot_mem.sv
module tlph_slot_mem #(
    parameter int MAX_SLOTS = 1024,
    parameter int AW        = 10
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  tlph_pkg::slot_entry_t wr_data,
    input  logic [AW-1:0]         rd_addr,
    output tlph_pkg::slot_entry_t rd_data
);
    import tlph_pkg::*;

    slot_entry_t mem [MAX_SLOTS];
    slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/tlph_probe_ctrl.sv
module tlph_probe_ctrl #(
    parameter int MAX_SLOTS = 1024,
    parameter int AW        = 10,
    parameter int CW        = 11
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [tlph_pkg::CAP_LOG_W-1:0]    capacity_log2,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  tlph_pkg::request_t                req,
    output logic                              res_valid,
    input  logic                              res_ready,
    output tlph_pkg::result_t                 res,
    output logic                              mem_wr_en,
    output logic [AW-1:0]                     mem_wr_addr,
    output tlph_pkg::slot_entry_t             mem_wr_data,
    output logic [AW-1:0]                     mem_rd_addr,
    input  tlph_pkg::slot_entry_t             mem_rd_data
);
    import tlph_pkg::*;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CLEAR = 3'd2;
    localparam logic [2:0] S_ISSUE = 3'd3;
    localparam logic [2:0] S_PROBE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam int CAP_WIDE_W = 17;
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_SLOTS - 1);

    logic [2:0]           state_reg, state_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [AW-1:0]        slot_reg, slot_next;
    logic [CW-1:0]        scanned_reg, scanned_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        cap_reg, cap_next;
    logic [CW-1:0]        limit_reg, limit_next;
    logic                 insert_reg, insert_next;
    logic [TAG_W-1:0]     tag_reg, tag_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [ROW_W-1:0]     res_row_reg, res_row_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;

    logic [CAP_LOG_W-1:0]  lg;
    logic [CAP_WIDE_W-1:0] cap_wide;
    logic [CW-1:0]         cap_now;
    logic [CW+2:0]         lim_wide;
    logic [AW-1:0]         mask_now;
    logic [AW-1:0]         mask;
    logic [AW-1:0]         slot_inc;
    logic [31:0]           slot_wide;
    logic                  hit_empty;
    logic                  hit_match;

    always_comb
    begin
        lg       = (capacity_log2 == '0) ? CAP_LOG_W'(1) : capacity_log2;
        cap_wide = CAP_WIDE_W'(1) << lg;
        cap_now  = (cap_wide > CAP_WIDE_W'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(cap_wide);
        lim_wide = (CW+3)'(cap_now) * (CW+3)'(7);
        mask_now = AW'(cap_now - CW'(1));
        mask     = AW'(cap_reg - CW'(1));
        slot_inc = (slot_reg + AW'(1)) & mask;
        slot_wide = 32'(slot_reg);
        hit_empty = (mem_rd_data.tag == TAG_EMPTY);
        hit_match = (mem_rd_data.tag == tag_reg) && (mem_rd_data.key == key_reg);
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        slot_next     = slot_reg;
        scanned_next  = scanned_reg;
        count_next    = count_reg;
        cap_next      = cap_reg;
        limit_next    = limit_reg;
        insert_next   = insert_reg;
        tag_next      = tag_reg;
        key_next      = key_reg;
        row_next      = row_reg;
        status_next   = status_reg;
        res_row_next  = res_row_reg;
        res_slot_next = res_slot_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = slot_reg;
        mem_wr_data   = '{tag: tag_reg, key: key_reg, row: row_reg};
        mem_rd_addr   = slot_reg;

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = clr_addr_reg;
                mem_wr_data   = '{tag: TAG_EMPTY, key: '0, row: '0};
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_SLOT)
                begin
                    clr_addr_next = '0;
                    count_next    = '0;
                    if (state_reg == S_CLEAR)
                    begin
                        status_next   = STAT_CLEARED;
                        res_row_next  = '0;
                        res_slot_next = '0;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cap_next     = cap_now;
                    limit_next   = lim_wide[CW+2:3];
                    insert_next  = (req.action == ACT_INSERT);
                    tag_next     = {1'b0, req.hash[HASH_W-1:TAG_LSB]};
                    key_next     = req.key;
                    row_next     = req.row;
                    slot_next    = req.hash[AW-1:0] & mask_now;
                    scanned_next = CW'(1);
                    if (req.action == ACT_CLEAR)
                    begin
                        clr_addr_next = '0;
                        state_next    = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ISSUE:
            begin
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                mem_rd_addr   = slot_inc;
                res_row_next  = '0;
                res_slot_next = '0;
                if (hit_empty)
                begin
                    state_next = S_DONE;
                    if (!insert_reg)
                    begin
                        status_next = STAT_NOT_FOUND;
                    end
                    else if (count_reg >= limit_reg)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        mem_wr_en     = 1'b1;
                        count_next    = count_reg + CW'(1);
                        status_next   = STAT_INSERTED;
                        res_slot_next = slot_wide[SLOT_W-1:0];
                    end
                end
                else if (hit_match)
                begin
                    state_next    = S_DONE;
                    res_slot_next = slot_wide[SLOT_W-1:0];
                    if (insert_reg)
                    begin
                        status_next = STAT_DUPLICATE;
                    end
                    else
                    begin
                        status_next  = STAT_FOUND;
                        res_row_next = mem_rd_data.row;
                    end
                end
                else if (scanned_reg == cap_reg)
                begin
                    state_next  = S_DONE;
                    status_next = STAT_EXHAUSTED;
                end
                else
                begin
                    slot_next    = slot_inc;
                    scanned_next = scanned_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            clr_addr_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        scanned_reg  <= scanned_next;
        cap_reg      <= cap_next;
        limit_reg    <= limit_next;
        insert_reg   <= insert_next;
        tag_reg      <= tag_next;
        key_reg      <= key_next;
        row_reg      <= row_next;
        status_reg   <= status_next;
        res_row_reg  <= res_row_next;
        res_slot_reg <= res_slot_next;
    end

    assign req_ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.status = status_reg;
    assign res.row    = res_row_reg;
    assign res.slot   = res_slot_reg;

endmodule
